>>> design/tpq_pkg.sv
// Shared types and constants of the touch pressure pen qualifier.
`default_nettype none
package tpq_pkg;

   // Converter reading and pressure widths
   localparam int SAMPLE_W   = 12;
   localparam int PRESSURE_W = 16;
   // x * (z2 - z1) needs both operand widths
   localparam int PROD_W     = 2 * SAMPLE_W;

   localparam logic [PRESSURE_W-1:0] LIMIT_RESET = 16'd15000;
   localparam int RELEASE_HOLD_DEFAULT = 2;

   // Stream payload widths, padded to whole bytes
   localparam int REQ_FIELDS_W = 1 + 4 * SAMPLE_W;
   localparam int REQ_DATA_W   = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = 1 + 2 * SAMPLE_W + PRESSURE_W + 3;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;
   localparam int ACTION_W     = 2;

   typedef enum logic [ACTION_W-1:0] {
      ACT_SAMPLE  = 2'd0,
      ACT_SUSPEND = 2'd1,
      ACT_RESUME  = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MULT,
      ST_DIV,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic capture;
      logic div_start;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic need_div;
      logic div_busy;
      logic out_free;
   } status_type;

endpackage
`default_nettype wire

>>> design/touch_pressure_pen_qualifier_unit.sv
// Top level of the touch pressure pen qualifier.
//
// Qualifies resistive touch panel events one transaction at a time. A sample
// event with the pen down computes pressure = x*(z2-z1)/z1 at full 24-bit
// width and drops the sample when x, y or z1 is zero, when z2 < z1, or when
// the pressure reaches the limit register; an accepted sample is stored and
// reported. After pen lift the release report (pressure 0, touch still set)
// waits RELEASE_HOLD_TICKS further timer events. Suspend forces a release and
// silences reports until resume. Every input transaction yields exactly one
// result transaction. A sample with the pen down and plausible readings passes
// through the accepting state, the multiply state, the divide state, in which
// the restoring divider produces its 24 quotient bits at one per cycle and is
// then seen to finish, and the commit state, which waits for a free output
// register. All other events go from the multiply state straight to the commit
// state. A result waits in the output register while the next transaction is
// taken in; a stalled result only holds back the commit of the following one.
`default_nettype none
module touch_pressure_pen_qualifier_unit #(
   parameter int RELEASE_HOLD_TICKS = tpq_pkg::RELEASE_HOLD_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // request: tdata = pen_touching, x_sample, y_sample, z1_sample, z2_sample
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [tpq_pkg::REQ_DATA_W-1:0]  req_tdata,
   // request: tuser = action
   input  wire logic [tpq_pkg::ACTION_W-1:0]    req_tuser,
   // response: tdata = report_valid, report_x, report_y, report_pressure,
   // touch_flag, arm_release_timer, enable_pen_irq
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic      [tpq_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // pressure limit register write
   input  wire logic                            csr_wr_en,
   input  wire logic [tpq_pkg::PRESSURE_W-1:0]  csr_wr_data
);

   localparam int SW = tpq_pkg::SAMPLE_W;
   localparam int PW = tpq_pkg::PRESSURE_W;
   // result field positions
   localparam int TOUCH_BIT = 2 * SW + PW + 1;

   tpq_pkg::cmd_type    cmd;
   tpq_pkg::status_type status;

   // Sequence each transaction through capture, divide and commit
   tpq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // Hold the limit, the pen state and the result register
   tpq_datapath #(
      .RELEASE_HOLD_TICKS (RELEASE_HOLD_TICKS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

   // One transaction in flight: input closes right after an acceptance
   a_single_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while a transaction is in flight");

   // Every emitted report carries the touch flag
   a_report_touch: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> rsp_tdata[TOUCH_BIT])
      else $error("report without touch flag");

   // Without a report the position and pressure fields are cleared
   a_quiet_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> (rsp_tdata[TOUCH_BIT:1] == '0))
      else $error("report fields set on a silent result");

   // A commit only happens with the output register free
   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> status.out_free)
      else $error("result committed over a pending result");

endmodule
`default_nettype wire

>>> design/tpq_divider.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module tpq_divider #(
   parameter int NUM_W = tpq_pkg::PROD_W,
   parameter int DEN_W = tpq_pkg::SAMPLE_W
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [NUM_W-1:0] numer,
   input  wire logic [DEN_W-1:0] denom,
   output logic                  busy,
   output logic      [NUM_W-1:0] quotient
);

   localparam int CNT_W = $clog2(NUM_W);

   logic             run_ff, run_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DEN_W:0]   shifted;
   logic             fits;

   assign shifted = {rem_ff, quo_ff[NUM_W-1]};
   assign fits    = shifted >= {1'b0, den_ff};

   always_comb begin
      run_in   = run_ff;
      count_in = count_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      if (start) begin
         run_in   = 1'b1;
         count_in = '0;
         quo_in   = numer;
         rem_in   = '0;
         den_in   = denom;
      end else if (run_ff) begin
         // shift the next dividend bit in, subtract where the divisor fits
         quo_in   = {quo_ff[NUM_W-2:0], fits};
         rem_in   = fits ? DEN_W'(shifted - {1'b0, den_ff}) : shifted[DEN_W-1:0];
         count_in = count_ff + CNT_W'(1);
         if (count_ff == CNT_W'(NUM_W - 1)) begin
            run_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff   <= 1'b0;
         count_ff <= '0;
      end else begin
         run_ff   <= run_in;
         count_ff <= count_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign busy     = run_ff;
   assign quotient = quo_ff;

endmodule
`default_nettype wire

>>> design/tpq_datapath.sv
// Datapath: input capture, pressure arithmetic, pen state and result register.
`default_nettype none
module tpq_datapath #(
   parameter int RELEASE_HOLD_TICKS = tpq_pkg::RELEASE_HOLD_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire tpq_pkg::cmd_type                cmd,
   output tpq_pkg::status_type                  status,
   input  wire logic [tpq_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  wire logic [tpq_pkg::ACTION_W-1:0]    req_tuser,
   input  wire logic                            csr_wr_en,
   input  wire logic [tpq_pkg::PRESSURE_W-1:0]  csr_wr_data,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic      [tpq_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   localparam int SW    = tpq_pkg::SAMPLE_W;
   localparam int PW    = tpq_pkg::PRESSURE_W;
   localparam int QW    = tpq_pkg::PROD_W;
   localparam int PEN_W = $clog2(RELEASE_HOLD_TICKS + 2);

   // captured transaction
   tpq_pkg::action_type act_ff;
   logic          touch_ff;
   logic [SW-1:0] x_ff, y_ff, z1_ff, z2_ff;

   // persistent state
   logic [PW-1:0]    limit_ff;
   logic [PEN_W-1:0] pen_ff, pen_in;
   logic [SW-1:0]    lx_ff, lx_in, ly_ff, ly_in;
   logic [PW-1:0]    lp_ff, lp_in;
   logic             susp_ff, susp_in;

   // result register
   logic                          rsp_valid_ff;
   logic [tpq_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic          pre_ok;
   logic [QW-1:0] product, quotient;
   logic          div_busy;
   logic          o_report, o_arm, o_irq;
   logic [SW-1:0] o_x, o_y;
   logic [PW-1:0] o_p;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         act_ff   <= tpq_pkg::action_type'(req_tuser);
         touch_ff <= req_tdata[0];
         x_ff     <= req_tdata[SW:1];
         y_ff     <= req_tdata[2*SW:SW+1];
         z1_ff    <= req_tdata[3*SW:2*SW+1];
         z2_ff    <= req_tdata[4*SW:3*SW+1];
      end
   end

   assign pre_ok  = (x_ff != '0) && (y_ff != '0) && (z1_ff != '0) && (z2_ff >= z1_ff);
   assign product = QW'(x_ff) * QW'(SW'(z2_ff - z1_ff));

   tpq_divider #(
      .NUM_W (QW),
      .DEN_W (SW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .numer    (product),
      .denom    (z1_ff),
      .busy     (div_busy),
      .quotient (quotient)
   );

   always_comb begin
      pen_in   = pen_ff;
      lx_in    = lx_ff;
      ly_in    = ly_ff;
      lp_in    = lp_ff;
      susp_in  = susp_ff;
      o_report = 1'b0;
      o_arm    = 1'b0;
      o_irq    = 1'b0;
      case (act_ff)
         tpq_pkg::ACT_SAMPLE: begin
            if (touch_ff) begin
               o_arm = 1'b1;
               if (pre_ok && (quotient < QW'(limit_ff))) begin
                  lx_in    = x_ff;
                  ly_in    = y_ff;
                  lp_in    = quotient[PW-1:0];
                  pen_in   = PEN_W'(1);
                  o_report = !susp_ff;
               end else begin
                  lp_in = '0;
               end
            end else if ((pen_ff != '0) && (pen_ff <= PEN_W'(RELEASE_HOLD_TICKS))) begin
               pen_in = pen_ff + PEN_W'(1);
               o_arm  = 1'b1;
            end else begin
               if (pen_ff != '0) begin
                  lp_in    = '0;
                  o_report = !susp_ff;
               end
               o_irq  = 1'b1;
               pen_in = '0;
            end
         end
         tpq_pkg::ACT_SUSPEND: begin
            if (pen_ff != '0) begin
               lp_in    = '0;
               o_report = !susp_ff;
               pen_in   = '0;
            end
            susp_in = 1'b1;
         end
         tpq_pkg::ACT_RESUME: begin
            o_irq   = 1'b1;
            susp_in = 1'b0;
         end
         default: begin
         end
      endcase
      o_x = o_report ? lx_in : '0;
      o_y = o_report ? ly_in : '0;
      o_p = o_report ? lp_in : '0;
      rsp_data_in = tpq_pkg::RSP_DATA_W'({o_irq, o_arm, o_report, o_p, o_y, o_x, o_report});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= tpq_pkg::LIMIT_RESET;
         pen_ff       <= '0;
         lx_ff        <= '0;
         ly_ff        <= '0;
         lp_ff        <= '0;
         susp_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
         if (cmd.commit) begin
            pen_ff       <= pen_in;
            lx_ff        <= lx_in;
            ly_ff        <= ly_in;
            lp_ff        <= lp_in;
            susp_ff      <= susp_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (cmd.commit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign status.need_div = (act_ff == tpq_pkg::ACT_SAMPLE) && touch_ff && pre_ok;
   assign status.div_busy = div_busy;
   assign status.out_free = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
`default_nettype wire

>>> design/tpq_ctrl.sv
// Controller state machine sequencing capture, divide and commit.
`default_nettype none
module tpq_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire tpq_pkg::status_type status,
   output tpq_pkg::cmd_type         cmd
);

   tpq_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tpq_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         tpq_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = tpq_pkg::ST_MULT;
            end
         end
         tpq_pkg::ST_MULT: begin
            // load the product into the divider only for a plausible sample
            if (status.need_div) begin
               cmd.div_start = 1'b1;
               state_in      = tpq_pkg::ST_DIV;
            end else begin
               state_in = tpq_pkg::ST_DONE;
            end
         end
         tpq_pkg::ST_DIV: begin
            if (!status.div_busy) begin
               state_in = tpq_pkg::ST_DONE;
            end
         end
         tpq_pkg::ST_DONE: begin
            if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = tpq_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tpq_pkg::ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire
